FILE: hw/rtl/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg: shared types and helpers for the 4x4 matrix inverse
// Holds the sequencer state type, the arithmetic unit controls and the
// small index functions that walk the terms of a 3x3 minor.
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

  // Default word format: signed Q16.16.
  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned FracBitsDef = 16;

  // Operations of the shared multiply/divide unit.
  typedef enum logic {
    UNIT_MUL,
    UNIT_DIV
  } unit_op_e;

  // Control bundle from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctl_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH,
    ST_MUL1,
    ST_WAIT1,
    ST_MUL2,
    ST_WAIT2,
    ST_ACC,
    ST_DMUL,
    ST_DWAIT,
    ST_DACC,
    ST_DCHECK,
    ST_DIVSET,
    ST_DIVWAIT,
    ST_RESULT,
    ST_OUT
  } state_e;

  // Index k of the three kept rows or columns when one index is skipped.
  function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] k);
    skip_idx = (k < skip) ? k : (k + 2'd1);
  endfunction

  // Column permutation of the six terms of a 3x3 determinant.
  function automatic logic [1:0] perm_digit(input logic [2:0] term, input logic [1:0] k);
    logic [5:0] p;
    case (term)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd1, 2'd2, 2'd0};
      3'd2:    p = {2'd2, 2'd0, 2'd1};
      3'd3:    p = {2'd0, 2'd2, 2'd1};
      3'd4:    p = {2'd1, 2'd0, 2'd2};
      3'd5:    p = {2'd0, 2'd1, 2'd2};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    case (k)
      2'd0:    perm_digit = p[1:0];
      2'd1:    perm_digit = p[3:2];
      default: perm_digit = p[5:4];
    endcase
  endfunction

  // Odd permutations carry a minus sign.
  function automatic logic perm_odd(input logic [2:0] term);
    perm_odd = (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
  endfunction

  // Store address of factor k of one term of the minor without row r, column c.
  function automatic logic [3:0] elem_addr(input logic [1:0] r, input logic [1:0] c,
                                           input logic [2:0] term, input logic [1:0] k);
    elem_addr = {skip_idx(r, k), skip_idx(c, perm_digit(term, k))};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mi4_muldiv.sv
// ----------------------------------------------------------------------------
// mi4_muldiv: shared bit-serial multiplier and divider
// Multiplies a wide signed value by a signed word, one multiplier bit per
// cycle, or divides two wide unsigned values, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_muldiv #(
  parameter int unsigned WordBits = mi4_pkg::WordBitsDef,
  parameter int unsigned BigBits  = 4 * mi4_pkg::WordBitsDef + 2 * mi4_pkg::FracBitsDef + 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mi4_pkg::unit_ctl_t  ctl_i,
  input  wire logic [BigBits-1:0]  a_i,
  input  wire logic [BigBits-1:0]  b_i,
  output logic                     busy_o,
  output logic [BigBits-1:0]       res_o
);

  import mi4_pkg::*;

  localparam int unsigned CntBits = $clog2(BigBits + 1);

  logic               busy_q;
  unit_op_e           op_q;
  logic [CntBits-1:0] cnt_q;
  logic [BigBits-1:0] a_q, b_q, acc_q, rem_q;

  logic               first;
  logic               mbit;
  logic [BigBits-1:0] addend;
  logic [BigBits-1:0] mul_next;
  logic [BigBits-1:0] rem_sh;
  logic               ge;

  // Multiply step: the sign bit of the word weighs negative, so it subtracts.
  always_comb begin
    first    = (cnt_q == CntBits'(WordBits));
    mbit     = b_q[WordBits-1];
    addend   = mbit ? (first ? ~a_q : a_q) : '0;
    mul_next = {acc_q[BigBits-2:0], 1'b0} + addend + BigBits'(mbit & first);
  end

  // Divide step: restoring, numerator shifted in from the top.
  always_comb begin
    rem_sh = {rem_q[BigBits-2:0], a_q[BigBits-1]};
    ge     = (rem_sh >= b_q);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= UNIT_MUL;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      op_q   <= ctl_i.op;
      cnt_q  <= (ctl_i.op == UNIT_MUL) ? CntBits'(WordBits) : CntBits'(BigBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      if (op_q == UNIT_MUL) begin
        acc_q <= mul_next;
        b_q   <= {b_q[BigBits-2:0], 1'b0};
      end else begin
        rem_q <= ge ? (rem_sh - b_q) : rem_sh;
        acc_q <= {acc_q[BigBits-2:0], ge};
        a_q   <= {a_q[BigBits-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign res_o  = acc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/matrix_inverse_4x4.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4: 4x4 fixed-point matrix inverse by cofactors
// Collects 16 elements, forms the exact determinant and divides each
// cofactor by it, emitting the inverse row by row with saturation.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Beat
//  --------+-------------------------------------------+-----------------------
//  in      | in_valid_i, in_ready_o, element_value_i   | one element, row-major
//  out     | out_valid_o, out_ready_i, inverse_value_o,| one inverse element
//          | out_row_o, out_col_o, singular_o,         |
//          | last_of_run_o                             |
//
// Element beats are taken while the block is loading. The serial unit then
// works through the 120 minor terms and four determinant products, and each
// non-singular output also needs a division, a result step and the beat.
// The default word format is Q16.16. A singular matrix skips the
// cofactors. The input is not ready during that work; reset returns to
// loading. A stalled output beat holds its value until taken.
`default_nettype none

module matrix_inverse_4x4 #(
  parameter int unsigned WordBits = mi4_pkg::WordBitsDef,
  parameter int unsigned FracBits = mi4_pkg::FracBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [WordBits-1:0] element_value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [WordBits-1:0]      inverse_value_o,
  output logic [1:0]                      out_row_o,
  output logic [1:0]                      out_col_o,
  output logic                            singular_o,
  output logic                            last_of_run_o
);

  import mi4_pkg::*;

  localparam int unsigned BigBits = 4 * WordBits + 2 * FracBits + 8;

  state_e state_q, state_d;

  logic [WordBits-1:0] store_q [16];
  logic [3:0]          count_q;
  logic [2:0]          term_q;
  logic [1:0]          cidx_q;
  logic [3:0]          oidx_q;
  logic                det_phase_q;
  logic                sing_q;
  logic                qneg_q;

  logic [WordBits-1:0] x_q;
  logic [BigBits-1:0]  cof_q, det_q, detmag_q;

  logic [WordBits-1:0] out_val_q;
  logic [1:0]          out_row_q, out_col_q;
  logic                out_sing_q, out_last_q;

  unit_ctl_t           ctl;
  logic [BigBits-1:0]  ua, ub, ures;
  logic                ubusy;

  logic [1:0]          cr, cc;
  logic [1:0]          fk;
  logic [3:0]          addr;
  logic [WordBits-1:0] elem;
  logic                tneg;
  logic [BigBits-1:0]  num_sh;
  logic                sat;
  logic [WordBits-1:0] qword;

  logic                in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Minor being worked on: row 0 during the determinant, else transposed index.
  always_comb begin
    cr   = det_phase_q ? 2'd0 : oidx_q[1:0];
    cc   = det_phase_q ? cidx_q : oidx_q[3:2];
    tneg = perm_odd(term_q) ^ cr[0] ^ cc[0];
  end

  // Element read port: factor select follows the sequencer state.
  always_comb begin
    case (state_q)
      ST_FETCH: fk = 2'd0;
      ST_MUL1:  fk = 2'd1;
      default:  fk = 2'd2;
    endcase
    addr = (state_q == ST_DMUL) ? {2'd0, cidx_q} : elem_addr(cr, cc, term_q, fk);
    elem = store_q[addr];
  end

  // Quotient saturation to the word range.
  always_comb begin
    num_sh = cof_q <<< (2 * FracBits);
    sat    = |ures[BigBits-1:WordBits-1];
    if (qneg_q) begin
      qword = sat ? {1'b1, {(WordBits-1){1'b0}}} : (~ures[WordBits-1:0] + WordBits'(1));
    end else begin
      qword = sat ? {1'b0, {(WordBits-1){1'b1}}} : ures[WordBits-1:0];
    end
  end

  // Next state and unit control.
  always_comb begin
    state_d   = state_q;
    ctl.start = 1'b0;
    ctl.op    = UNIT_MUL;
    ua        = {{(BigBits-WordBits){x_q[WordBits-1]}}, x_q};
    ub        = {{(BigBits-WordBits){elem[WordBits-1]}}, elem};
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && count_q == 4'd15) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_MUL1;
      ST_MUL1: begin
        ctl.start = 1'b1;
        state_d   = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (!ubusy) begin
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        ctl.start = 1'b1;
        ua        = ures;
        state_d   = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (!ubusy) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (term_q != 3'd5) begin
          state_d = ST_FETCH;
        end else begin
          state_d = det_phase_q ? ST_DMUL : ST_DIVSET;
        end
      end
      ST_DMUL: begin
        ctl.start = 1'b1;
        ua        = cof_q;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!ubusy) begin
          state_d = ST_DACC;
        end
      end
      ST_DACC: state_d = (cidx_q == 2'd3) ? ST_DCHECK : ST_FETCH;
      ST_DCHECK: state_d = (det_q == '0) ? ST_OUT : ST_FETCH;
      ST_DIVSET: begin
        ctl.start = 1'b1;
        ctl.op    = UNIT_DIV;
        ua        = cof_q[BigBits-1] ? (~num_sh + BigBits'(1)) : num_sh;
        ub        = detmag_q;
        state_d   = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (!ubusy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          if (oidx_q == 4'd15) begin
            state_d = ST_LOAD;
          end else if (!sing_q) begin
            state_d = ST_FETCH;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer counters and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      term_q      <= '0;
      cidx_q      <= '0;
      oidx_q      <= '0;
      det_phase_q <= 1'b0;
      sing_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            count_q <= count_q + 4'd1;
            if (count_q == 4'd15) begin
              term_q      <= '0;
              cidx_q      <= '0;
              oidx_q      <= '0;
              det_phase_q <= 1'b1;
            end
          end
        end
        ST_ACC: term_q <= (term_q == 3'd5) ? 3'd0 : (term_q + 3'd1);
        ST_DACC: cidx_q <= cidx_q + 2'd1;
        ST_DCHECK: begin
          det_phase_q <= 1'b0;
          sing_q      <= (det_q == '0);
        end
        ST_OUT: begin
          if (out_acc) begin
            oidx_q <= oidx_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Element store and arithmetic registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          store_q[count_q] <= element_value_i;
          cof_q            <= '0;
          det_q            <= '0;
        end
      end
      ST_FETCH: x_q <= elem;
      ST_ACC:   cof_q <= tneg ? (cof_q - ures) : (cof_q + ures);
      ST_DACC: begin
        det_q <= det_q + ures;
        cof_q <= '0;
      end
      ST_DCHECK: detmag_q <= det_q[BigBits-1] ? (~det_q + BigBits'(1)) : det_q;
      ST_DIVSET: qneg_q <= cof_q[BigBits-1] ^ det_q[BigBits-1];
      ST_RESULT: cof_q <= '0;
      default: ;
    endcase
  end

  // Output beat register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_val_q  <= '0;
      out_row_q  <= 2'd0;
      out_col_q  <= 2'd0;
      out_sing_q <= 1'b0;
      out_last_q <= 1'b0;
    end else if (state_q == ST_RESULT) begin
      out_val_q  <= qword;
      out_row_q  <= oidx_q[3:2];
      out_col_q  <= oidx_q[1:0];
      out_sing_q <= 1'b0;
      out_last_q <= (oidx_q == 4'd15);
    end else if (state_q == ST_DCHECK) begin
      out_val_q  <= '0;
      out_row_q  <= 2'd0;
      out_col_q  <= 2'd0;
      out_sing_q <= 1'b1;
      out_last_q <= 1'b0;
    end else if (state_q == ST_OUT && out_acc && sing_q) begin
      out_val_q  <= '0;
      out_row_q  <= oidx_q[3:2] + {1'b0, (oidx_q[1:0] == 2'd3)};
      out_col_q  <= oidx_q[1:0] + 2'd1;
      out_last_q <= (oidx_q == 4'd14);
    end
  end

  mi4_muldiv #(
    .WordBits (WordBits),
    .BigBits  (BigBits)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .a_i    (ua),
    .b_i    (ub),
    .busy_o (ubusy),
    .res_o  (ures)
  );

  assign in_ready_o      = (state_q == ST_LOAD);
  assign out_valid_o     = (state_q == ST_OUT);
  assign inverse_value_o = out_val_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign singular_o      = out_sing_q;
  assign last_of_run_o   = out_last_q;

endmodule

`default_nettype wire
